// File: hdl/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types and codes of the stack-machine execute step.
// ----------------------------------------------------------------------------
`default_nettype none
package svm_pkg;

  localparam int unsigned DataW      = 32;
  // variable store size and program bound, fixed by the 4-bit index and 9-bit pc
  localparam int unsigned NumVars    = 16;
  localparam int unsigned MaxProgram = 256;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_ASSIGN = 4'd4,
    OP_VAR    = 4'd5,
    OP_JMP    = 4'd6,
    OP_JMPEQ  = 4'd7,
    OP_JMPGT  = 4'd8,
    OP_JMPLT  = 4'd9,
    OP_CONST  = 4'd10,
    OP_PRINT  = 4'd11,
    OP_HALT   = 4'd12,
    OP_NOP    = 4'd13
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,
    ST_HALT = 2'd1,
    ST_ERR  = 2'd2,
    ST_END  = 2'd3
  } vm_status_e;

  // divider handshake between sequencer and divider
  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: hdl/svm_divider.sv
// ----------------------------------------------------------------------------
// svm_divider
// Signed 32-bit restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
`default_nettype none
module svm_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire svm_pkg::div_req_t req_i,
  output svm_pkg::div_rsp_t      rsp_o
);
  import svm_pkg::*;

  logic             busy_q, busy_d;
  logic [5:0]       cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic             neg_q, neg_d, done_q, done_d;
  logic [DataW:0]   trial;

  assign trial = {rem_q, quo_q[DataW-1]} - {1'b0, den_q};

  // magnitude setup and shift-subtract steps
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = '0;
      quo_d  = req_i.dividend[DataW-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
      den_d  = req_i.divisor[DataW-1] ? (~req_i.divisor + 1'b1) : req_i.divisor;
      neg_d  = req_i.dividend[DataW-1] ^ req_i.divisor[DataW-1];
    end else if (busy_q) begin
      if (!trial[DataW]) begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DataW-2:0], quo_q[DataW-1]};
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule
`default_nettype wire

// File: hdl/stack_vm_execute_step.sv
// ----------------------------------------------------------------------------
// stack_vm_execute_step
// Executes one decoded stack-machine instruction per input transfer.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_stall_o) carries one decoded
// instruction (kind, operand, var_index). The output channel (out_valid_o /
// out_stall_i) returns one result per instruction: status, next pc and any
// printed value. in_stall_o is high from the accepted transfer until the
// result has left the output register.
// Sequence: the sequencer reads the two top stack entries one per cycle
// (states S_RDA, S_WAITA), executes in S_EXEC and presents the result in
// S_OUT. Mul with two entries writes back from S_DIVW instead of S_EXEC;
// div waits in S_DIVW for the one-bit-per-cycle divider. While stopped or
// past the program end the instruction goes straight to S_OUT. One
// instruction at a time; the next transfer can follow in the cycle after.
// Reset clears stack count, variables, variable valid bits, pc and status
// and sets program_length to 256. Stack memory contents are not cleared.
// After a halt or error, instructions still transfer and return the held
// status and pc. A stalled result holds in the output register until taken.
// The cfg channel (cfg_valid_i / cfg_ready_o) writes program_length; it is
// ready whenever no instruction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
module stack_vm_execute_step #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [8:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  kind_i,
  input  wire logic [31:0] operand_i,
  input  wire logic [3:0]  var_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [8:0]       next_pc_o,
  output logic             print_valid_o,
  output logic [31:0]      print_value_o
);
  import svm_pkg::*;

  localparam int unsigned SpW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VarW = (NumVars > 1) ? $clog2(NumVars) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RDA, S_WAITA, S_EXEC, S_DIVW, S_OUT
  } seq_e;

  seq_e               st_q;
  logic [CntW-1:0]    cnt_q;
  logic [8:0]         pc_q, len_q;
  vm_status_e         stat_q;
  logic [NumVars-1:0] vvalid_q;
  logic [DataW-1:0]   vars_q [NumVars];
  logic [DataW-1:0]   stk_mem [STACK_DEPTH];
  logic [DataW-1:0]   rd_q, b_q;
  logic [SpW-1:0]     rd_addr;
  logic               wr_en;
  logic [SpW-1:0]     wr_addr;
  logic [DataW-1:0]   wr_data;
  op_kind_e           kind_q;
  logic [31:0]        opnd_q;
  logic [VarW-1:0]    vi_q;
  logic [DataW-1:0]   mul_q;
  logic               prv_q;
  logic [31:0]        prval_q;
  div_req_t           dreq;
  div_rsp_t           drsp;
  logic [16:0]        eff_len;
  logic [16:0]        pc_ext;

  // effective program length: 0 acts as 1, clamp to MaxProgram
  always_comb begin
    eff_len = {8'd0, len_q};
    if (len_q == 9'd0) eff_len = 17'd1;
    if (eff_len > 17'(MaxProgram)) eff_len = 17'(MaxProgram);
  end
  assign pc_ext = {8'd0, pc_q};

  // stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) stk_mem[wr_addr] <= wr_data;
    rd_q <= stk_mem[rd_addr];
  end

  svm_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign cfg_ready_o   = (st_q == S_IDLE);
  assign in_stall_o    = (st_q != S_IDLE);
  assign out_valid_o   = (st_q == S_OUT);
  assign status_o      = stat_q;
  assign next_pc_o     = pc_q;
  assign print_valid_o = prv_q;
  assign print_value_o = prval_q;

  // read address: top on accept, next entry for the rest of the instruction
  always_comb begin
    rd_addr = SpW'(cnt_q - CntW'(1));
    if (st_q != S_IDLE) rd_addr = SpW'(cnt_q - CntW'(2));
  end

  logic [CntW-1:0] pop2;
  logic            is_bin, is_cj, take, jerr;
  logic signed [31:0] ls, rs;
  assign pop2   = cnt_q - CntW'(2);
  assign is_bin = (kind_q == OP_ADD) || (kind_q == OP_SUB) || (kind_q == OP_MUL)
                  || (kind_q == OP_DIV);
  assign is_cj  = (kind_q == OP_JMPEQ) || (kind_q == OP_JMPGT) || (kind_q == OP_JMPLT);
  assign ls     = b_q;
  assign rs     = rd_q;
  always_comb begin
    case (kind_q)
      OP_JMPEQ: take = (ls == rs);
      OP_JMPGT: take = (ls < rs);
      OP_JMPLT: take = (ls > rs);
      default:  take = 1'b1;
    endcase
  end
  assign jerr = opnd_q[31] || ({1'b0, opnd_q} >= {16'd0, eff_len});

  // write port and divider request
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = SpW'(pop2);
    wr_data = rd_q;
    dreq    = '0;
    dreq.dividend = rd_q;
    dreq.divisor  = b_q;
    if (st_q == S_EXEC) begin
      case (kind_q)
        OP_ADD: begin wr_en = 1'b1; wr_data = rd_q + b_q; end
        OP_SUB: begin wr_en = 1'b1; wr_data = rd_q - b_q; end
        OP_DIV: dreq.start = 1'b1;
        OP_VAR: begin
          wr_en   = (|vvalid_q) && (cnt_q < CntW'(STACK_DEPTH));
          wr_addr = SpW'(cnt_q);
          wr_data = vars_q[vi_q];
        end
        OP_CONST: begin
          wr_en   = (cnt_q < CntW'(STACK_DEPTH));
          wr_addr = SpW'(cnt_q);
          wr_data = opnd_q;
        end
        default: ;
      endcase
    end else if (st_q == S_WAITA && kind_q == OP_MUL) begin
      wr_en   = 1'b0;
    end else if (st_q == S_DIVW && kind_q == OP_MUL) begin
      wr_en   = 1'b1;
      wr_data = mul_q;
    end else if (st_q == S_DIVW && drsp.done) begin
      wr_en   = 1'b1;
      wr_data = (rd_q == 32'h8000_0000 && b_q == 32'hFFFF_FFFF) ? rd_q : drsp.quotient;
    end
  end

  // finish helper: advance pc or stop
  logic [8:0] npc;
  assign npc = pc_q + 9'd1;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      cnt_q    <= '0;
      pc_q     <= '0;
      len_q    <= 9'd256;
      stat_q   <= ST_RUN;
      vvalid_q <= '0;
      vars_q   <= '{default: '0};
      b_q      <= '0;
      mul_q    <= '0;
      prv_q    <= 1'b0;
      prval_q  <= '0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (cfg_valid_i) len_q <= cfg_data_i;
          if (in_valid_i) begin
            prv_q   <= 1'b0;
            prval_q <= '0;
            if (stat_q != ST_RUN) st_q <= S_OUT;
            else if (pc_ext >= eff_len) begin
              stat_q <= ST_END;
              st_q   <= S_OUT;
            end else st_q <= S_RDA;
          end
        end
        S_RDA: begin
          // rd_q now holds the top
          b_q  <= rd_q;
          st_q <= S_WAITA;
        end
        S_WAITA: begin
          // rd_q now holds the next entry
          mul_q <= rd_q * b_q;
          if (kind_q == OP_MUL && cnt_q >= CntW'(2)) st_q <= S_DIVW;
          else st_q <= S_EXEC;
        end
        S_EXEC: begin
          if (kind_q == OP_DIV && cnt_q >= CntW'(2) && b_q != '0) st_q <= S_DIVW;
          else st_q <= S_OUT;
          if (is_bin) begin
            if (cnt_q < CntW'(2)) stat_q <= ST_ERR;
            else if (kind_q == OP_DIV) begin
              if (b_q == '0) begin
                stat_q <= ST_ERR;
                cnt_q  <= cnt_q - CntW'(1);
              end
            end else begin
              cnt_q <= cnt_q - CntW'(1);
              pc_q  <= npc;
              if ({8'd0, npc} >= eff_len) stat_q <= ST_END;
            end
          end else begin
            case (kind_q)
              OP_ASSIGN: begin
                if (cnt_q == '0) stat_q <= ST_ERR;
                else begin
                  vars_q[vi_q]   <= b_q;
                  vvalid_q[vi_q] <= 1'b1;
                  cnt_q <= cnt_q - CntW'(1);
                end
              end
              OP_VAR: begin
                if (!(|vvalid_q)) stat_q <= ST_ERR;
                else begin
                  vvalid_q[vi_q] <= 1'b1;
                  if (cnt_q >= CntW'(STACK_DEPTH)) stat_q <= ST_ERR;
                  else cnt_q <= cnt_q + CntW'(1);
                end
              end
              OP_CONST: begin
                if (cnt_q >= CntW'(STACK_DEPTH)) stat_q <= ST_ERR;
                else cnt_q <= cnt_q + CntW'(1);
              end
              OP_PRINT: begin
                if (!vvalid_q[vi_q]) stat_q <= ST_ERR;
                else begin
                  prv_q   <= 1'b1;
                  prval_q <= vars_q[vi_q];
                end
              end
              OP_HALT: stat_q <= ST_HALT;
              default: ;
            endcase
            if (is_cj) begin
              if (cnt_q < CntW'(2)) stat_q <= ST_ERR;
              else cnt_q <= pop2;
            end
            if (is_cj && cnt_q < CntW'(2)) begin
              // error already flagged
            end else if (kind_q == OP_JMP || (is_cj && take)) begin
              if (jerr) stat_q <= ST_ERR;
              else pc_q <= opnd_q[8:0];
            end else if (!(kind_q == OP_ASSIGN && cnt_q == '0)
                         && !(kind_q == OP_VAR && (!(|vvalid_q)
                              || cnt_q >= CntW'(STACK_DEPTH)))
                         && !(kind_q == OP_CONST && cnt_q >= CntW'(STACK_DEPTH))
                         && !(kind_q == OP_PRINT && !vvalid_q[vi_q])
                         && kind_q != OP_HALT) begin
              pc_q <= npc;
              if ({8'd0, npc} >= eff_len) stat_q <= ST_END;
            end
          end
        end
        S_DIVW: begin
          if (kind_q == OP_MUL || drsp.done) begin
            cnt_q <= cnt_q - CntW'(1);
            pc_q  <= npc;
            if ({8'd0, npc} >= eff_len) stat_q <= ST_END;
            st_q  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  // latch the instruction on transfer
  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && in_valid_i) begin
      kind_q <= op_kind_e'(kind_i);
      opnd_q <= operand_i;
      vi_q   <= VarW'(var_index_i);
    end
  end

endmodule
`default_nettype wire
